[hdl/ccgc_pkg.sv]
// Package for the cons-cell heap: command, status, register index and
// state codes. No dependencies.
`default_nettype none
package ccgc_pkg;
  localparam int unsigned VAL_W = 33;

  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_CONS  = 3'd1,
    CMD_MARK  = 3'd2,
    CMD_SWEEP = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic CFG_INIT_BATCH   = 1'b0;
  localparam logic CFG_EXTEND_BATCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COMMIT,
    S_CONS_RD,
    S_CONS_WR,
    S_MARK_POP,
    S_MARK_RD,
    S_MARK_CHK,
    S_MARK_PUSH,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_READ_RD,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

[hdl/ccgc_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ccgc_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/cons_cell_heap_mark_sweep.sv]
// Cons-cell heap with free list, lazy batch commit and mark-sweep.
// Cons commits a further batch of cells when the free list runs dry; init
// commits the first batch, mark traces each cell reached and sweep visits
// every committed cell. One command at a time: in_stall stays high until
// the result has been taken. Reset empties the store.
`default_nettype none
module cons_cell_heap_mark_sweep
  import ccgc_pkg::*;
#(
  parameter int unsigned POOL_CELLS  = 4096,
  parameter int unsigned TRACE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire logic        in_car_is_cell,
  input  wire logic [31:0] in_car_word,
  input  wire logic        in_cdr_is_cell,
  input  wire logic [31:0] in_cdr_word,
  input  wire logic [11:0] in_read_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [11:0]      out_new_cell,
  output logic [12:0]      out_used_cells,
  output logic             out_free_empty,
  output logic             out_out_car_is_cell,
  output logic [31:0]      out_out_car_word,
  output logic             out_out_cdr_is_cell,
  output logic [31:0]      out_out_cdr_word
);
  localparam int unsigned AW = $clog2(POOL_CELLS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned TW = $clog2(TRACE_DEPTH);
  localparam logic [CW-1:0] POOL = CW'(POOL_CELLS);

  state_t state_r, state_nxt;
  logic [12:0] init_batch_r, extend_batch_r;
  logic [2:0] cmd_r;
  logic [VAL_W-1:0] car_r, cdr_r, cur_r, cur_nxt, a_r, a_nxt;
  logic [11:0] ridx_r;
  logic [AW-1:0] head_r, head_nxt;
  logic free_valid_r, free_valid_nxt;
  logic [CW-1:0] comm_r, comm_nxt, used_r, used_nxt;
  logic [CW-1:0] i_r, i_nxt, hi_r, hi_nxt;
  logic [TW:0] top_r, top_nxt;
  logic [1:0] st_r, st_nxt;
  logic [11:0] nc_r, nc_nxt;
  logic [VAL_W-1:0] rcar_r, rcar_nxt, rcdr_r, rcdr_nxt;
  logic ov_r, ov_nxt;

  logic f_we, s_we, m_we, t_we;
  logic [AW-1:0] f_wa, s_wa, m_wa, c_ra;
  logic [VAL_W-1:0] f_wd, s_wd, t_wd;
  logic m_wd;
  logic [VAL_W-1:0] f_rd, s_rd, t_rd;
  logic m_rd;
  logic [TW-1:0] t_wa, t_ra;

  ccgc_ram #(.WIDTH(VAL_W), .DEPTH(POOL_CELLS)) u_first (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(c_ra), .rdata(f_rd));
  ccgc_ram #(.WIDTH(VAL_W), .DEPTH(POOL_CELLS)) u_second (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(c_ra), .rdata(s_rd));
  ccgc_ram #(.WIDTH(1), .DEPTH(POOL_CELLS)) u_marks (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(c_ra), .rdata(m_rd));
  ccgc_ram #(.WIDTH(VAL_W), .DEPTH(TRACE_DEPTH)) u_trace (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

  logic accept;
  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign accept   = in_valid && !in_stall;
  assign out_valid = ov_r;

  logic [CW-1:0] ib_cl, ext_sum, ext_end;
  logic [13:0] ib14;
  logic [CW:0] es_w;
  always_comb begin
    ib14   = {1'b0, init_batch_r};
    ib_cl  = (ib14 > 14'(POOL_CELLS)) ? POOL : CW'(ib14);
    es_w   = (CW+1)'(comm_r) + (CW+1)'(extend_batch_r);
    ext_end = (es_w > (CW+1)'(POOL_CELLS)) ? POOL : CW'(es_w);
    ext_sum = ext_end;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt = cur_r; a_nxt = a_r;
    head_nxt = head_r; free_valid_nxt = free_valid_r;
    comm_nxt = comm_r; used_nxt = used_r;
    i_nxt = i_r; hi_nxt = hi_r; top_nxt = top_r;
    st_nxt = st_r; nc_nxt = nc_r; rcar_nxt = rcar_r; rcdr_nxt = rcdr_r;
    ov_nxt = ov_r;
    f_we = 1'b0; s_we = 1'b0; m_we = 1'b0; t_we = 1'b0;
    f_wa = i_r[AW-1:0]; s_wa = i_r[AW-1:0]; m_wa = i_r[AW-1:0];
    f_wd = '0; s_wd = '0; m_wd = 1'b0; t_wd = '0;
    c_ra = i_r[AW-1:0];
    t_wa = top_r[TW-1:0]; t_ra = top_r[TW-1:0] - 1'b1;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt = ST_OK; nc_nxt = '0; rcar_nxt = '0; rcdr_nxt = '0;
          unique case (in_cmd)
            CMD_INIT: begin
              free_valid_nxt = 1'b0; head_nxt = '0; comm_nxt = '0; used_nxt = '0;
              i_nxt = '0; hi_nxt = ib_cl; state_nxt = S_COMMIT;
            end
            CMD_CONS: begin
              if (!free_valid_r && comm_r < POOL) begin
                i_nxt = comm_r; hi_nxt = ext_sum; state_nxt = S_COMMIT;
              end else begin
                state_nxt = S_CONS_RD;
              end
            end
            CMD_MARK: begin
              t_we = 1'b1; t_wa = '0; t_wd = {in_car_is_cell, in_car_word};
              top_nxt = (TW+1)'(1); state_nxt = S_MARK_POP;
            end
            CMD_SWEEP: begin
              free_valid_nxt = 1'b0; head_nxt = '0; used_nxt = '0;
              i_nxt = comm_r; state_nxt = S_SWEEP_RD;
            end
            CMD_READ: state_nxt = S_READ_RD;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_COMMIT: begin
        if (i_r >= hi_r) begin
          state_nxt = (cmd_r == CMD_CONS) ? S_CONS_RD : S_DONE;
        end else begin
          f_we = 1'b1; s_we = 1'b1; m_we = 1'b1;
          if (i_r + 1'b1 < hi_r) s_wd = {1'b1, 32'(i_r + 1'b1)};
          else if (free_valid_r) s_wd = {1'b1, 32'(head_r)};
          else s_wd = '0;
          i_nxt = i_r + 1'b1;
          if (i_r + 1'b1 >= hi_r) begin
            head_nxt = hi_r == comm_r ? head_r : AW'(comm_r);
            free_valid_nxt = 1'b1;
            comm_nxt = hi_r;
            if (cmd_r == CMD_INIT) head_nxt = '0;
            state_nxt = (cmd_r == CMD_CONS) ? S_CONS_RD : S_DONE;
          end
        end
      end
      S_CONS_RD: begin
        if (!free_valid_r) begin
          st_nxt = ST_OOM; state_nxt = S_DONE;
        end else begin
          c_ra = head_r; state_nxt = S_CONS_WR;
        end
      end
      S_CONS_WR: begin
        if (s_rd[32] && s_rd[31:0] < 32'(comm_r)) head_nxt = AW'(s_rd[31:0]);
        else begin head_nxt = '0; free_valid_nxt = 1'b0; end
        f_we = 1'b1; s_we = 1'b1; m_we = 1'b1;
        f_wa = head_r; s_wa = head_r; m_wa = head_r;
        f_wd = car_r; s_wd = cdr_r;
        used_nxt = used_r + 1'b1;
        nc_nxt = 12'(head_r);
        state_nxt = S_DONE;
      end
      S_MARK_POP: begin
        if (top_r == '0) state_nxt = S_DONE;
        else begin
          top_nxt = top_r - 1'b1; state_nxt = S_MARK_RD;
        end
      end
      S_MARK_RD: begin
        cur_nxt = t_rd;
        c_ra = AW'(t_rd[31:0]);
        state_nxt = S_MARK_CHK;
      end
      S_MARK_CHK: begin
        if (cur_r[32] && cur_r[31:0] < 32'(comm_r) && !m_rd) begin
          m_we = 1'b1; m_wa = AW'(cur_r[31:0]); m_wd = 1'b1;
          a_nxt = f_rd;
          if (32'(top_r) + 1 < TRACE_DEPTH) begin
            t_we = 1'b1; t_wd = s_rd; top_nxt = top_r + 1'b1;
          end
          state_nxt = S_MARK_PUSH;
        end else state_nxt = S_MARK_POP;
      end
      S_MARK_PUSH: begin
        if (32'(top_r) + 1 < TRACE_DEPTH) begin
          t_we = 1'b1; t_wd = a_r; top_nxt = top_r + 1'b1;
        end
        state_nxt = S_MARK_POP;
      end
      S_SWEEP_RD: begin
        if (i_r == '0) state_nxt = S_DONE;
        else begin
          i_nxt = i_r - 1'b1; c_ra = AW'(i_r - 1'b1); state_nxt = S_SWEEP_WR;
        end
      end
      S_SWEEP_WR: begin
        if (m_rd) begin
          m_we = 1'b1; used_nxt = used_r + 1'b1;
        end else begin
          s_we = 1'b1; f_we = 1'b1;
          s_wd = free_valid_r ? {1'b1, 32'(head_r)} : '0;
          head_nxt = i_r[AW-1:0]; free_valid_nxt = 1'b1;
        end
        state_nxt = S_SWEEP_RD;
      end
      S_READ_RD: begin
        c_ra = AW'(ridx_r);
        if (32'(ridx_r) >= 32'(comm_r)) st_nxt = ST_RANGE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd_r == CMD_READ && st_r == ST_OK) begin
          rcar_nxt = f_rd; rcdr_nxt = s_rd;
        end
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
      init_batch_r <= 13'd1024; extend_batch_r <= 13'd1024;
      free_valid_r <= 1'b0; head_r <= '0; comm_r <= '0; used_r <= '0;
      top_r <= '0; i_r <= '0; hi_r <= '0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_INIT_BATCH) init_batch_r <= cfg_data;
        else extend_batch_r <= cfg_data;
      end
      free_valid_r <= free_valid_nxt; head_r <= head_nxt;
      comm_r <= comm_nxt; used_r <= used_nxt;
      top_r <= top_nxt; i_r <= i_nxt; hi_r <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd; ridx_r <= in_read_index;
      car_r <= {in_car_is_cell, in_car_word};
      cdr_r <= {in_cdr_is_cell, in_cdr_word};
    end
    cur_r <= cur_nxt; a_r <= a_nxt;
    st_r <= st_nxt; nc_r <= nc_nxt; rcar_r <= rcar_nxt; rcdr_r <= rcdr_nxt;
  end

  assign out_status          = st_r;
  assign out_new_cell        = nc_r;
  assign out_used_cells      = 13'(used_r);
  assign out_free_empty      = !free_valid_r;
  assign out_out_car_is_cell = rcar_r[32];
  assign out_out_car_word    = rcar_r[31:0];
  assign out_out_cdr_is_cell = rcdr_r[32];
  assign out_out_cdr_word    = rcdr_r[31:0];
endmodule
`default_nettype wire
